/* sv/rar_pkg.sv */
// shared types and constants for the rational arithmetic block
// no dependencies; compiled first
package rar_pkg;

   localparam int RES_NUM_W   = 33;
   localparam int RES_DEN_W   = 32;
   localparam int OP_W        = 2;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [OP_W-1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } rar_op_type;

   // classification of a transaction made by the front end
   typedef struct packed {
      logic add_path;
      logic zero_den;
   } rar_kind_type;

   localparam int KIND_W = $bits(rar_kind_type);

endpackage

/* sv/rar_if.sv */
// request and response channel interfaces for the rational arithmetic block
// depends on rar_pkg for the operation and result widths
interface rar_req_if #(parameter int OPERAND_WIDTH = 16) ();
   logic                            valid;
   logic                            ready;
   logic signed [OPERAND_WIDTH-1:0] a_num;
   logic signed [OPERAND_WIDTH-1:0] a_den;
   logic [rar_pkg::OP_W-1:0]        operation;
   logic signed [OPERAND_WIDTH-1:0] b_num;
   logic signed [OPERAND_WIDTH-1:0] b_den;

   modport source (output valid, a_num, a_den, operation, b_num, b_den, input ready);
   modport sink   (input valid, a_num, a_den, operation, b_num, b_den, output ready);
endinterface

interface rar_rsp_if ();
   logic                               valid;
   logic                               ready;
   logic signed [rar_pkg::RES_NUM_W-1:0] res_num;
   logic [rar_pkg::RES_DEN_W-1:0]      res_den;
   logic                               zero_den_error;

   modport source (output valid, res_num, res_den, zero_den_error, input ready);
   modport sink   (input valid, res_num, res_den, zero_den_error, output ready);
endinterface

/* sv/rar_front.sv */
// front end: applies the operation to the second fraction and classifies the transaction
// depends on rar_pkg and rar_req_if
module rar_front #(
   parameter int  OPERAND_WIDTH = 16,
   localparam int W             = OPERAND_WIDTH,
   localparam int DW            = rar_pkg::KIND_W + 4 * W + 2
) (
   rar_req_if.sink   req,
   output logic      push_valid,
   input  logic      push_ready,
   output logic [DW-1:0] push_data
);

   logic signed [W:0]     n2_x;
   logic signed [W:0]     d2_x;
   logic signed [W:0]     n2_c;
   logic signed [W:0]     d2_c;
   rar_pkg::rar_op_type   op;
   rar_pkg::rar_kind_type kind;

   assign op   = rar_pkg::rar_op_type'(req.operation);
   assign n2_x = $signed({req.b_num[W-1], req.b_num});
   assign d2_x = $signed({req.b_den[W-1], req.b_den});

   always_comb begin
      n2_c = n2_x;
      d2_c = d2_x;
      case (op)
         rar_pkg::OP_SUB: begin
            n2_c = -n2_x;
         end
         rar_pkg::OP_DIV: begin
            // multiply by the inverse
            n2_c = d2_x;
            d2_c = n2_x;
         end
         default: begin
            n2_c = n2_x;
         end
      endcase
      kind.add_path = (op inside {rar_pkg::OP_ADD, rar_pkg::OP_SUB});
      // result denominator is zero exactly when a_den or the second denominator after the divide swap is
      kind.zero_den = (req.a_den == '0) || (d2_c == '0);
   end

   assign push_valid = req.valid;
   assign req.ready  = push_ready;
   assign push_data  = {kind, req.a_num, req.a_den, n2_c, d2_c};

endmodule

/* sv/rar_queue.sv */
// short fifo between the front end and the back end
// depends on rar_pkg for the depth
module rar_queue #(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [DATA_W-1:0] in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [DATA_W-1:0] out_data
);

   localparam int DEPTH = rar_pkg::QUEUE_DEPTH;
   localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff;
   logic [PW-1:0]     wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff;
   logic [PW-1:0]     rd_ptr_in;
   logic [CW-1:0]     count_ff;
   logic [CW-1:0]     count_in;
   logic              push;
   logic              pop;

   assign in_ready  = (count_ff != CW'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

/* sv/rar_gcd.sv */
// binary gcd unit, one step per cycle, for two nonzero magnitudes
// no dependencies
module rar_gcd #(
   parameter int MAG_W = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [MAG_W-1:0] x_val,
   input  logic [MAG_W-1:0] y_val,
   output logic             done,
   output logic [MAG_W-1:0] g_out
);

   localparam int KW = $clog2(MAG_W);

   logic             busy_ff;
   logic             busy_in;
   logic             done_ff;
   logic             done_in;
   logic [MAG_W-1:0] x_ff;
   logic [MAG_W-1:0] x_in;
   logic [MAG_W-1:0] y_ff;
   logic [MAG_W-1:0] y_in;
   logic [KW-1:0]    k_ff;
   logic [KW-1:0]    k_in;
   logic [MAG_W-1:0] g_ff;
   logic [MAG_W-1:0] g_in;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      x_in    = x_ff;
      y_in    = y_ff;
      k_in    = k_ff;
      g_in    = g_ff;
      if (start) begin
         busy_in = 1'b1;
         x_in    = x_val;
         y_in    = y_val;
         k_in    = '0;
      end else if (busy_ff) begin
         if (x_ff == y_ff) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            g_in    = x_ff << k_ff;
         end else if (!x_ff[0] && !y_ff[0]) begin
            // common factor of two
            x_in = x_ff >> 1;
            y_in = y_ff >> 1;
            k_in = k_ff + 1'b1;
         end else if (!x_ff[0]) begin
            x_in = x_ff >> 1;
         end else if (!y_ff[0]) begin
            y_in = y_ff >> 1;
         end else if (x_ff > y_ff) begin
            x_in = (x_ff - y_ff) >> 1;
         end else begin
            y_in = (y_ff - x_ff) >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      k_ff <= k_in;
      g_ff <= g_in;
   end

   assign done  = done_ff;
   assign g_out = g_ff;

endmodule

/* sv/rar_div.sv */
// bit-serial restoring divider, two dividends over one shared divisor
// no dependencies
module rar_div #(
   parameter int MAG_W = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [MAG_W-1:0] a_val,
   input  logic [MAG_W-1:0] b_val,
   input  logic [MAG_W-1:0] dv_val,
   output logic             done,
   output logic [MAG_W-1:0] qa_out,
   output logic [MAG_W-1:0] qb_out
);

   localparam int CW = $clog2(MAG_W + 1);

   logic             busy_ff;
   logic             busy_in;
   logic             done_ff;
   logic             done_in;
   logic [CW-1:0]    cnt_ff;
   logic [CW-1:0]    cnt_in;
   logic [MAG_W-1:0] ra_ff;
   logic [MAG_W-1:0] ra_in;
   logic [MAG_W-1:0] rb_ff;
   logic [MAG_W-1:0] rb_in;
   logic [MAG_W-1:0] qa_ff;
   logic [MAG_W-1:0] qa_in;
   logic [MAG_W-1:0] qb_ff;
   logic [MAG_W-1:0] qb_in;
   logic [MAG_W-1:0] dv_ff;
   logic [MAG_W-1:0] dv_in;

   // one quotient bit: returns {remainder, shifted quotient}
   function automatic logic [2*MAG_W-1:0] div_step(
      input logic [MAG_W-1:0] r,
      input logic [MAG_W-1:0] q,
      input logic [MAG_W-1:0] dv
   );
      logic [MAG_W:0] sh;
      logic [MAG_W:0] diff;
      logic           ge;
      sh   = {r, q[MAG_W-1]};
      diff = sh - {1'b0, dv};
      ge   = (sh >= {1'b0, dv});
      return ge ? {diff[MAG_W-1:0], q[MAG_W-2:0], 1'b1}
                : {sh[MAG_W-1:0], q[MAG_W-2:0], 1'b0};
   endfunction

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      ra_in   = ra_ff;
      rb_in   = rb_ff;
      qa_in   = qa_ff;
      qb_in   = qb_ff;
      dv_in   = dv_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(MAG_W);
         ra_in   = '0;
         rb_in   = '0;
         qa_in   = a_val;
         qb_in   = b_val;
         dv_in   = dv_val;
      end else if (busy_ff) begin
         {ra_in, qa_in} = div_step(ra_ff, qa_ff, dv_ff);
         {rb_in, qb_in} = div_step(rb_ff, qb_ff, dv_ff);
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      ra_ff  <= ra_in;
      rb_ff  <= rb_in;
      qa_ff  <= qa_in;
      qb_ff  <= qb_in;
      dv_ff  <= dv_in;
   end

   assign done   = done_ff;
   assign qa_out = qa_ff;
   assign qb_out = qb_ff;

endmodule

/* sv/rar_back.sv */
// back end: sequencer that forms the raw fraction and reduces it to lowest terms
// depends on rar_pkg, rar_gcd and rar_div
module rar_back #(
   parameter int  OPERAND_WIDTH = 16,
   localparam int W             = OPERAND_WIDTH,
   localparam int DW            = rar_pkg::KIND_W + 4 * W + 2,
   localparam int NUM_W         = rar_pkg::RES_NUM_W,
   localparam int DEN_W         = rar_pkg::RES_DEN_W
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_valid,
   output logic                    q_ready,
   input  logic [DW-1:0]           q_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [NUM_W-1:0] res_num,
   output logic [DEN_W-1:0]        res_den,
   output logic                    res_err
);

   localparam int MW  = 2 * W;
   localparam int SW  = 2 * W + 1;
   localparam int PRW = 2 * W + 2;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_GCD1  = 8'b0000_0010,
      S_DIV1  = 8'b0000_0100,
      S_MULT  = 8'b0000_1000,
      S_CHECK = 8'b0001_0000,
      S_GCD2  = 8'b0010_0000,
      S_DIV2  = 8'b0100_0000,
      S_DONE  = 8'b1000_0000
   } rar_state_type;

   rar_pkg::rar_kind_type q_kind;
   logic signed [W-1:0]   q_n1;
   logic signed [W-1:0]   q_d1;
   logic signed [W:0]     q_n2;
   logic signed [W:0]     q_d2;

   rar_state_type         state_ff;
   rar_state_type         state_in;
   logic                  add_ff;
   logic                  add_in;
   logic signed [W-1:0]   n1_ff;
   logic signed [W-1:0]   n1_in;
   logic signed [W-1:0]   d1_ff;
   logic signed [W-1:0]   d1_in;
   logic signed [W:0]     n2_ff;
   logic signed [W:0]     n2_in;
   logic signed [W:0]     d2_ff;
   logic signed [W:0]     d2_in;
   logic signed [W:0]     e1_ff;
   logic signed [W:0]     e1_in;
   logic signed [W:0]     e2_ff;
   logic signed [W:0]     e2_in;
   logic [1:0]            mstep_ff;
   logic [1:0]            mstep_in;
   logic signed [PRW-1:0] prod_ff;
   logic signed [PRW-1:0] prod_in;
   logic signed [SW-1:0]  acc_ff;
   logic signed [SW-1:0]  acc_in;
   logic signed [SW-1:0]  rd_ff;
   logic signed [SW-1:0]  rd_in;
   logic signed [SW-1:0]  fin_num_ff;
   logic signed [SW-1:0]  fin_num_in;
   logic [MW-1:0]         fin_den_ff;
   logic [MW-1:0]         fin_den_in;
   logic                  fin_err_ff;
   logic                  fin_err_in;
   logic                  out_valid_ff;
   logic                  out_valid_in;
   logic signed [NUM_W-1:0] out_num_ff;
   logic signed [NUM_W-1:0] out_num_in;
   logic [DEN_W-1:0]      out_den_ff;
   logic [DEN_W-1:0]      out_den_in;
   logic                  out_err_ff;
   logic                  out_err_in;

   logic signed [W:0]     mul_a;
   logic signed [W:0]     mul_b;
   logic signed [PRW-1:0] mul_p;
   logic signed [W:0]     qa_short;
   logic signed [W:0]     qb_short;
   logic signed [SW-1:0]  qa_full;

   logic                  gcd_start;
   logic [MW-1:0]         gcd_x;
   logic [MW-1:0]         gcd_y;
   logic                  gcd_done;
   logic [MW-1:0]         gcd_g;
   logic                  div_start;
   logic [MW-1:0]         div_a;
   logic [MW-1:0]         div_b;
   logic                  div_done;
   logic [MW-1:0]         div_qa;
   logic [MW-1:0]         div_qb;

   function automatic logic [MW-1:0] mag_of(input logic signed [SW-1:0] v);
      logic [SW-1:0] u;
      u = v[SW-1] ? SW'(-v) : SW'(v);
      return MW'(u);
   endfunction

   assign {q_kind, q_n1, q_d1, q_n2, q_d2} = q_data;
   assign q_ready = (state_ff == S_IDLE);

   // gcd of the denominators first on the add path, of the raw result later
   assign gcd_start = ((state_ff == S_IDLE) && q_valid && !q_kind.zero_den && q_kind.add_path)
                   || ((state_ff == S_CHECK) && (acc_ff != '0));
   assign gcd_x = (state_ff == S_IDLE) ? mag_of(SW'(q_d1)) : mag_of(acc_ff);
   assign gcd_y = (state_ff == S_IDLE) ? mag_of(SW'(q_d2)) : mag_of(rd_ff);

   assign div_start = ((state_ff == S_GCD1) || (state_ff == S_GCD2)) && gcd_done;
   assign div_a = (state_ff == S_GCD1) ? mag_of(SW'(d2_ff)) : mag_of(acc_ff);
   assign div_b = (state_ff == S_GCD1) ? mag_of(SW'(d1_ff)) : mag_of(rd_ff);

   rar_gcd #(.MAG_W(MW)) u_gcd (
      .clock (clock),
      .reset (reset),
      .start (gcd_start),
      .x_val (gcd_x),
      .y_val (gcd_y),
      .done  (gcd_done),
      .g_out (gcd_g)
   );

   rar_div #(.MAG_W(MW)) u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .a_val  (div_a),
      .b_val  (div_b),
      .dv_val (gcd_g),
      .done   (div_done),
      .qa_out (div_qa),
      .qb_out (div_qb)
   );

   // quotients of the denominators by their gcd fit the operand width
   assign qa_short = $signed({1'b0, div_qa[W-1:0]});
   assign qb_short = $signed({1'b0, div_qb[W-1:0]});
   assign qa_full  = $signed({1'b0, div_qa});

   // multiplier operands per step: numerator terms, then denominator
   always_comb begin
      case (mstep_ff)
         2'd0: begin
            mul_a = $signed({n1_ff[W-1], n1_ff});
            mul_b = add_ff ? e2_ff : n2_ff;
         end
         2'd1: begin
            mul_a = add_ff ? n2_ff : '0;
            mul_b = add_ff ? e1_ff : '0;
         end
         2'd2: begin
            mul_a = $signed({d1_ff[W-1], d1_ff});
            mul_b = add_ff ? e2_ff : d2_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = PRW'(mul_a) * PRW'(mul_b);

   always_comb begin
      state_in     = state_ff;
      add_in       = add_ff;
      n1_in        = n1_ff;
      d1_in        = d1_ff;
      n2_in        = n2_ff;
      d2_in        = d2_ff;
      e1_in        = e1_ff;
      e2_in        = e2_ff;
      mstep_in     = mstep_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      rd_in        = rd_ff;
      fin_num_in   = fin_num_ff;
      fin_den_in   = fin_den_ff;
      fin_err_in   = fin_err_ff;
      out_valid_in = out_valid_ff;
      out_num_in   = out_num_ff;
      out_den_in   = out_den_ff;
      out_err_in   = out_err_ff;

      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               add_in   = q_kind.add_path;
               n1_in    = q_n1;
               d1_in    = q_d1;
               n2_in    = q_n2;
               d2_in    = q_d2;
               mstep_in = '0;
               if (q_kind.zero_den) begin
                  fin_err_in = 1'b1;
                  fin_num_in = '0;
                  fin_den_in = '0;
                  state_in   = S_DONE;
               end else if (q_kind.add_path) begin
                  state_in = S_GCD1;
               end else begin
                  state_in = S_MULT;
               end
            end
         end
         S_GCD1: begin
            if (gcd_done) begin
               state_in = S_DIV1;
            end
         end
         S_DIV1: begin
            if (div_done) begin
               // signed d2/g and d1/g
               e2_in    = d2_ff[W] ? -qa_short : qa_short;
               e1_in    = d1_ff[W-1] ? -qb_short : qb_short;
               mstep_in = '0;
               state_in = S_MULT;
            end
         end
         S_MULT: begin
            mstep_in = mstep_ff + 1'b1;
            prod_in  = mul_p;
            case (mstep_ff)
               2'd1: begin
                  acc_in = SW'(prod_ff);
               end
               2'd2: begin
                  acc_in = acc_ff + SW'(prod_ff);
               end
               2'd3: begin
                  rd_in    = SW'(prod_ff);
                  state_in = S_CHECK;
               end
               default: begin
                  acc_in = acc_ff;
               end
            endcase
         end
         S_CHECK: begin
            if (acc_ff == '0) begin
               fin_num_in = '0;
               fin_den_in = MW'(1);
               fin_err_in = 1'b0;
               state_in   = S_DONE;
            end else begin
               state_in = S_GCD2;
            end
         end
         S_GCD2: begin
            if (gcd_done) begin
               state_in = S_DIV2;
            end
         end
         S_DIV2: begin
            if (div_done) begin
               // sign moves onto the numerator
               fin_num_in = (acc_ff[SW-1] ^ rd_ff[SW-1]) ? -qa_full : qa_full;
               fin_den_in = div_qb;
               fin_err_in = 1'b0;
               state_in   = S_DONE;
            end
         end
         S_DONE: begin
            if (!out_valid_ff || rsp_ready) begin
               out_valid_in = 1'b1;
               out_num_in   = NUM_W'(fin_num_ff);
               out_den_in   = DEN_W'(fin_den_ff);
               out_err_in   = fin_err_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      add_ff     <= add_in;
      n1_ff      <= n1_in;
      d1_ff      <= d1_in;
      n2_ff      <= n2_in;
      d2_ff      <= d2_in;
      e1_ff      <= e1_in;
      e2_ff      <= e2_in;
      mstep_ff   <= mstep_in;
      prod_ff    <= prod_in;
      acc_ff     <= acc_in;
      rd_ff      <= rd_in;
      fin_num_ff <= fin_num_in;
      fin_den_ff <= fin_den_in;
      fin_err_ff <= fin_err_in;
      out_num_ff <= out_num_in;
      out_den_ff <= out_den_in;
      out_err_ff <= out_err_in;
   end

   assign rsp_valid = out_valid_ff;
   assign res_num   = out_num_ff;
   assign res_den   = out_den_ff;
   assign res_err   = out_err_ff;

endmodule

/* sv/rational_arith_reduce.sv */
// top level of the rational arithmetic block: front end, queue and back end
// depends on rar_pkg, rar_if, rar_front, rar_queue and rar_back
//
// adds, subtracts, multiplies or divides two signed fractions a_num/a_den and
// b_num/b_den and returns the result in lowest terms, sign on the numerator and
// a positive denominator; 0/1 for a zero numerator, and 0/0 with zero_den_error
// set when the result denominator is zero. transactions use valid/ready on both
// channels. the front end classifies each request and parks it in a two-entry
// queue, so requests keep being taken while the back end works as long as the
// queue has room; the back end handles one transaction at a time. its time per
// transaction is set by the binary gcd unit (one step per cycle) and by the
// bit-serial divider, each used twice for add or subtract and once for multiply
// or divide, once less for a zero result; a zero denominator uses neither. the
// response sits in an output register until taken
module rational_arith_reduce #(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic      clock,
   input  logic      reset,
   rar_req_if.sink   req_chan,
   rar_rsp_if.source rsp_chan
);

   localparam int DW = rar_pkg::KIND_W + 4 * OPERAND_WIDTH + 2;

   // front end to queue
   logic          push_valid;
   logic          push_ready;
   logic [DW-1:0] push_data;
   // queue to back end
   logic          pop_valid;
   logic          pop_ready;
   logic [DW-1:0] pop_data;

   // operation applied to the second fraction, zero denominator flagged early
   rar_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
      .req        (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // decouples request acceptance from the long back end sequence
   rar_queue #(.DATA_W(DW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_data   (push_data),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_data  (pop_data)
   );

   // gcd, exact divides and products, then the registered response
   rar_back #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (pop_valid),
      .q_ready   (pop_ready),
      .q_data    (pop_data),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .res_num   (rsp_chan.res_num),
      .res_den   (rsp_chan.res_den),
      .res_err   (rsp_chan.zero_den_error)
   );

endmodule

/* sv/rar_checker.sv */
// port-level checks on the response channel of the rational arithmetic block
// depends on rar_pkg; bound to rational_arith_reduce
module rar_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [rar_pkg::RES_NUM_W-1:0] res_num,
   input logic [rar_pkg::RES_DEN_W-1:0]      res_den,
   input logic                               res_err
);

   // no response right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(res_num) && $stable(res_den)
                                   && $stable(res_err))
      else $error("stalled response changed");

   // zero denominator gives 0/0
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && res_err |-> (res_num == '0) && (res_den == '0))
      else $error("error response not 0/0");

   // reduced terms are never both even
   a_reduced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !res_err |-> res_num[0] || res_den[0])
      else $error("response not in lowest terms");

endmodule

bind rational_arith_reduce rar_checker u_rar_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .res_num   (rsp_chan.res_num),
   .res_den   (rsp_chan.res_den),
   .res_err   (rsp_chan.zero_den_error)
);

/* test/tb_rational_arith_reduce.sv */
// self-checking testbench for rational_arith_reduce: directed and random fractions
// depends on rar_pkg, rar_if and the rational_arith_reduce rtl
`timescale 1ns / 100ps

module tb_rational_arith_reduce;

   localparam int OW          = 16;
   localparam int QUIET_LIMIT = 5000;   // cycles with no transaction on either channel
   localparam int TAIL_CYCLES = 400;    // wait at the end for any extra result

   // one request as the sender sees it
   typedef struct {
      logic signed [OW-1:0] a_num;
      logic signed [OW-1:0] a_den;
      rar_pkg::rar_op_type  op;
      logic signed [OW-1:0] b_num;
      logic signed [OW-1:0] b_den;
   } frac_request_type;

   // one reduced fraction as the block should return it
   typedef struct {
      logic signed [rar_pkg::RES_NUM_W-1:0] res_num;
      logic [rar_pkg::RES_DEN_W-1:0]        res_den;
      logic                                 zero_den_error;
   } frac_result_type;

   logic clock = 1'b0;
   logic reset;

   rar_req_if #(.OPERAND_WIDTH(OW)) req_chan ();
   rar_rsp_if                       rsp_chan ();

   rational_arith_reduce #(.OPERAND_WIDTH(OW)) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // reduced fractions still owed by the block, oldest first
   frac_result_type pending_results[$];
   int              mismatch_count = 0;
   int              quiet_cycles   = 0;
   bit              idle_on        = 1'b1;   // both sides insert random gaps when set

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------------

   function automatic longint magnitude(input longint x);
      return (x < 0) ? -x : x;
   endfunction

   // plain euclid on non-negative values
   function automatic longint euclid_gcd(input longint x, input longint y);
      longint r;
      while (y != 0) begin
         r = x % y;
         x = y;
         y = r;
      end
      return x;
   endfunction

   function automatic frac_result_type reduce_fraction(input frac_request_type rq);
      longint          n1, d1, n2, d2, rn, rd, g, t;
      frac_result_type r;
      n1 = rq.a_num;
      d1 = rq.a_den;
      n2 = rq.b_num;
      d2 = rq.b_den;
      // subtract is add of the negated second fraction
      if (rq.op == rar_pkg::OP_SUB) n2 = -n2;
      // divide is multiply by the inverse
      if (rq.op == rar_pkg::OP_DIV) begin
         t  = n2;
         n2 = d2;
         d2 = t;
      end
      if (rq.op == rar_pkg::OP_ADD || rq.op == rar_pkg::OP_SUB) begin
         // no gcd when a denominator is zero, the result is flagged below
         if (d1 == 0 || d2 == 0) begin
            rn = 0;
            rd = 0;
         end else begin
            g  = euclid_gcd(magnitude(d1), magnitude(d2));
            rn = n1 * (d2 / g) + n2 * (d1 / g);
            rd = d1 * (d2 / g);
         end
      end else begin
         rn = n1 * n2;
         rd = d1 * d2;
      end
      if (rd == 0) begin
         // zero denominator: 0/0 with the error flag
         r.res_num        = '0;
         r.res_den        = '0;
         r.zero_den_error = 1'b1;
      end else if (rn == 0) begin
         // zero numerator reduces to 0/1
         r.res_num        = '0;
         r.res_den        = 1;
         r.zero_den_error = 1'b0;
      end else begin
         g  = euclid_gcd(magnitude(rn), magnitude(rd));
         rn = rn / g;
         rd = rd / g;
         // sign lives on the numerator
         if (rd < 0) begin
            rn = -rn;
            rd = -rd;
         end
         r.res_num        = rn[rar_pkg::RES_NUM_W-1:0];
         r.res_den        = rd[rar_pkg::RES_DEN_W-1:0];
         r.zero_den_error = 1'b0;
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // sender: one request transaction, with an optional random gap in front
   // ---------------------------------------------------------------------------

   task automatic send_fraction(input logic signed [OW-1:0] an, input logic signed [OW-1:0] ad,
                                input rar_pkg::rar_op_type op,
                                input logic signed [OW-1:0] bn, input logic signed [OW-1:0] bd);
      frac_request_type rq;
      int               gap;
      rq.a_num = an;
      rq.a_den = ad;
      rq.op    = op;
      rq.b_num = bn;
      rq.b_den = bd;
      gap = idle_on ? $urandom_range(0, 3) : 0;
      // valid only drops when there is a real gap, so it never toggles within one step
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.a_num     <= an;
      req_chan.a_den     <= ad;
      req_chan.operation <= op;
      req_chan.b_num     <= bn;
      req_chan.b_den     <= bd;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      pending_results.push_back(reduce_fraction(rq));
   endtask

   // sender goes quiet until every owed result has come back
   task automatic wait_for_results();
      req_chan.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // operand mix: full range, small values for lots of reduction, extremes,
   // zero, and shifted values with many common factors
   function automatic logic signed [OW-1:0] draw_operand(input bit is_den);
      int                   v;
      logic signed [OW-1:0] x;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            v = $urandom;
            x = v[OW-1:0];
         end
         4, 5, 6: begin
            v = int'($urandom_range(0, 32)) - 16;
            x = v[OW-1:0];
         end
         7: begin
            case ($urandom_range(0, 4))
               0:       x = 16'sh8000;
               1:       x = -16'sd1;
               2:       x = 16'sd0;
               3:       x = 16'sd1;
               default: x = 16'sh7fff;
            endcase
         end
         8: begin
            // denominators draw zero only half the time here, small nonzero values otherwise
            if (is_den && $urandom_range(0, 1)) begin
               v = int'($urandom_range(1, 9));
               x = v[OW-1:0];
            end else begin
               x = '0;
            end
         end
         default: begin
            v = int'($urandom_range(1, 255)) << $urandom_range(0, 7);
            if ($urandom_range(0, 1)) v = -v;
            x = v[OW-1:0];
         end
      endcase
      return x;
   endfunction

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------

   // largest and most negative operands through every operation
   task automatic test_field_extremes();
      for (int k = 0; k < 4; k++) begin
         send_fraction(16'sh8000, 16'sh8000, rar_pkg::rar_op_type'(k), 16'sh8000, 16'sh8000);
         send_fraction(16'sh7fff, 16'sh7fff, rar_pkg::rar_op_type'(k), 16'sh7fff, 16'sh8000);
      end
      send_fraction(16'sh8000, 16'sd1, rar_pkg::OP_SUB, 16'sh7fff, 16'sd1);
      send_fraction(16'sh7fff, -16'sd1, rar_pkg::OP_MUL, 16'sh8000, 16'sd1);
   endtask

   task automatic test_special_cases();
      // zero denominators, flagged as 0/0
      send_fraction(16'sd3, 16'sd0, rar_pkg::OP_ADD, 16'sd1, 16'sd2);
      send_fraction(16'sd3, 16'sd5, rar_pkg::OP_MUL, 16'sd1, 16'sd0);
      send_fraction(16'sd1, 16'sd0, rar_pkg::OP_ADD, 16'sd1, 16'sd0);   // both zero, no gcd taken
      send_fraction(16'sd0, 16'sd0, rar_pkg::OP_SUB, 16'sd0, 16'sd0);
      send_fraction(16'sd7, 16'sd3, rar_pkg::OP_DIV, 16'sd0, 16'sd5);   // divide by zero numerator
      // zero numerators, reduced to 0/1
      send_fraction(16'sd7, 16'sd3, rar_pkg::OP_DIV, 16'sd4, 16'sd0);
      send_fraction(16'sd1, 16'sd2, rar_pkg::OP_SUB, 16'sd1, 16'sd2);
      send_fraction(16'sd0, 16'sd5, rar_pkg::OP_MUL, 16'sd3, -16'sd7);
      send_fraction(16'sd0, -16'sd3, rar_pkg::OP_ADD, 16'sd0, 16'sd4);
      // negative denominators move their sign to the numerator; common factors reduce
      send_fraction(16'sd1, -16'sd2, rar_pkg::OP_ADD, 16'sd1, 16'sd3);
      send_fraction(-16'sd5, -16'sd10, rar_pkg::OP_MUL, -16'sd4, -16'sd6);
      send_fraction(16'sd6, 16'sd8, rar_pkg::OP_ADD, 16'sd10, 16'sd12);
      send_fraction(16'sd9, -16'sd4, rar_pkg::OP_DIV, -16'sd3, 16'sd8);
   endtask

   task automatic test_random_mix(input int count, input bit with_idle);
      logic signed [OW-1:0] an, ad, bn, bd;
      idle_on = with_idle;
      for (int i = 0; i < count; i++) begin
         an = draw_operand(1'b0);
         ad = draw_operand(1'b1);
         bn = draw_operand(1'b0);
         bd = draw_operand(1'b1);
         send_fraction(an, ad, rar_pkg::rar_op_type'($urandom_range(0, 3)), bn, bd);
      end
      idle_on = 1'b1;
   endtask

   // bursts separated by a full drain of the block
   task automatic test_drain_pause();
      for (int burst = 0; burst < 3; burst++) begin
         test_random_mix(20, burst[0]);
         wait_for_results();
      end
   endtask

   // ---------------------------------------------------------------------------
   // stimulus sequence
   // ---------------------------------------------------------------------------

   initial begin
      reset              <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.a_num     <= '0;
      req_chan.a_den     <= '0;
      req_chan.operation <= rar_pkg::OP_ADD;
      req_chan.b_num     <= '0;
      req_chan.b_den     <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_field_extremes();
      test_special_cases();
      test_random_mix(700, 1'b1);
      test_random_mix(300, 1'b0);
      test_drain_pause();
      test_random_mix(900, 1'b1);

      wait_for_results();
      // anything arriving now is an extra result and gets flagged by the checker
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("rational_arith_reduce regression: pass");
      end else begin
         $display("rational_arith_reduce regression: fail");
      end
      $finish;
   end

   // ---------------------------------------------------------------------------
   // receiver and checker: random back-pressure, each result against the oldest
   // expectation
   // ---------------------------------------------------------------------------

   initial begin
      frac_result_type exp_res;
      int              gap;
      rsp_chan.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         gap = idle_on ? $urandom_range(0, 3) : 0;
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid && rsp_chan.ready));
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %0d/%0d err %0b",
                     $time, rsp_chan.res_num, rsp_chan.res_den, rsp_chan.zero_den_error);
            mismatch_count++;
         end else begin
            exp_res = pending_results.pop_front();
            if (rsp_chan.res_num !== exp_res.res_num) begin
               $display("%0t: res_num mismatch, expected %0d, actual %0d",
                        $time, exp_res.res_num, rsp_chan.res_num);
               mismatch_count++;
            end
            if (rsp_chan.res_den !== exp_res.res_den) begin
               $display("%0t: res_den mismatch, expected %0d, actual %0d",
                        $time, exp_res.res_den, rsp_chan.res_den);
               mismatch_count++;
            end
            if (rsp_chan.zero_den_error !== exp_res.zero_den_error) begin
               $display("%0t: zero_den_error mismatch, expected %0b, actual %0b",
                        $time, exp_res.zero_den_error, rsp_chan.zero_den_error);
               mismatch_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // watchdog: stops a hung run when no transaction moves for too long
   // ---------------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles = quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: timeout, no transaction for %0d cycles, %0d results outstanding",
                  $time, quiet_cycles, pending_results.size());
         $display("rational_arith_reduce regression: fail");
         $finish;
      end
   end

endmodule
